[hdl/cau_pkg.sv]
// Shared types, widths and helper functions for the complex arithmetic unit.
// Used by every module in hdl/; depends on nothing else.
package cau_pkg;

  // Operand format: signed fixed point, DATA_W bits with FRAC_BITS fraction bits.
  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;

  // Exact products and sums of two products.
  localparam int PROD_W    = 2 * DATA_W;
  // Quotient bits kept before saturation: anything of 2^QBITS or more saturates.
  localparam int QBITS     = DATA_W + 1;
  // Divider remainder: the scaled numerator stays below d * 2^QBITS.
  localparam int REM_W     = PROD_W + QBITS;
  // Width of the early overflow compare, numerator against d * 2^(QBITS - FRAC_BITS).
  localparam int PRESAT_W  = PROD_W + QBITS - FRAC_BITS;
  // Magnitude width handed to the final saturation.
  localparam int MAG_W     = PROD_W + 2;
  // Iteration counts of the divider and of the square root.
  localparam int DIV_STEPS = QBITS;
  localparam int SQ_STEPS  = DATA_W;
  localparam int ITER_STAGES = DIV_STEPS;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_CDIV = 4'd3,
    OP_RDIV = 4'd4,
    OP_CONJ = 4'd5,
    OP_NEG  = 4'd6,
    OP_ABS2 = 4'd7,
    OP_ABS  = 4'd8
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  // One item as it moves through the divider and square root stages.
  typedef struct packed {
    op_t                     op;
    logic [DATA_W-1:0]       simple_re;
    logic [DATA_W-1:0]       simple_im;
    logic                    simple_sat;
    logic                    dz;
    logic                    neg_re;
    logic                    neg_im;
    logic                    ovf_re;
    logic                    ovf_im;
    logic [PROD_W-1:0]       mag_re;
    logic [PROD_W-1:0]       mag_im;
    logic [PROD_W-1:0]       d;
    logic [REM_W-1:0]        rem_re;
    logic [REM_W-1:0]        rem_im;
    logic [QBITS-1:0]        q_re;
    logic [QBITS-1:0]        q_im;
    logic [PROD_W-1:0]       sq_n;
    logic [PROD_W-1:0]       sq_res;
  } item_t;

  // Saturate a sum that has grown by one bit. Returns {saturated, value}.
  function automatic logic [DATA_W:0] sat_sum(input logic [DATA_W:0] s);
    logic [DATA_W-1:0] v;
    logic              sat;
    sat = (s[DATA_W] != s[DATA_W-1]);
    if (!sat) begin
      v = s[DATA_W-1:0];
    end else if (s[DATA_W]) begin
      v = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      v = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return {sat, v};
  endfunction

  // Turn sign and magnitude into a saturated field. Returns {saturated, value}.
  function automatic logic [DATA_W:0] pack_mag(input logic neg, input logic [MAG_W-1:0] m);
    logic [MAG_W-1:0]  lim;
    logic [MAG_W-1:0]  mm;
    logic [DATA_W-1:0] v;
    logic              sat;
    lim = MAG_W'(1) << (DATA_W - 1);
    mm  = m;
    sat = 1'b0;
    if (!neg && (m > lim - MAG_W'(1))) begin
      sat = 1'b1;
      mm  = lim - MAG_W'(1);
    end
    if (neg && (m > lim)) begin
      sat = 1'b1;
      mm  = lim;
    end
    v = neg ? (DATA_W'(0) - mm[DATA_W-1:0]) : mm[DATA_W-1:0];
    return {sat, v};
  endfunction

endpackage

[hdl/complex_arithmetic_unit.sv]
// Top level of the complex arithmetic unit, signed Q16.16 operands.
// Instantiates cau_front, cau_iter and cau_back; depends on cau_pkg.
//
//   Channel  Handshake            Payload
//   input    start, busy          in_command, in_a_re, in_a_im, in_b_re, in_b_im
//   result   out_valid (strobe)   out_result_re, out_result_im, out_status
//
// One item is taken per cycle while busy is low; each result passes through
// three front stages, 33 divide stages (one quotient bit per stage) that also hold
// the square root steps, and two rounding and saturation stages.
// busy is high only in the cycle after reset; a synchronous reset drops all items
// in flight. Results are shown for one cycle on out_valid and cannot be held off.
module complex_arithmetic_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [3:0]                          in_command,
  input  logic signed [cau_pkg::DATA_W-1:0]   in_a_re,
  input  logic signed [cau_pkg::DATA_W-1:0]   in_a_im,
  input  logic signed [cau_pkg::DATA_W-1:0]   in_b_re,
  input  logic signed [cau_pkg::DATA_W-1:0]   in_b_im,
  output logic                                out_valid,
  output logic signed [cau_pkg::DATA_W-1:0]   out_result_re,
  output logic signed [cau_pkg::DATA_W-1:0]   out_result_im,
  output logic [1:0]                          out_status
);
  import cau_pkg::*;

  logic    busy_r;
  logic    acc;
  logic    fr_vld, it_vld, bk_vld;
  item_t   fr_item, it_item;
  logic [DATA_W-1:0] bk_re, bk_im;
  status_t bk_status;

  // The pipeline never stalls; busy only covers the cycle leaving reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;
  assign acc  = start & ~busy_r;

  cau_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (acc),
    .in_op    (op_t'(in_command)),
    .in_a_re  (in_a_re),
    .in_a_im  (in_a_im),
    .in_b_re  (in_b_re),
    .in_b_im  (in_b_im),
    .out_vld  (fr_vld),
    .out_item (fr_item)
  );

  cau_iter u_iter (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (fr_vld),
    .in_item  (fr_item),
    .out_vld  (it_vld),
    .out_item (it_item)
  );

  cau_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (it_vld),
    .in_item    (it_item),
    .out_vld    (bk_vld),
    .out_re     (bk_re),
    .out_im     (bk_im),
    .out_status (bk_status)
  );

  assign out_valid     = bk_vld;
  assign out_result_re = bk_re;
  assign out_result_im = bk_im;
  assign out_status    = bk_status;

endmodule

[hdl/cau_front.sv]
// Front end of the complex arithmetic unit: products, sums, magnitudes, simple ops.
// Three register stages; depends on cau_pkg.
module cau_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_vld,
  input  cau_pkg::op_t                           in_op,
  input  logic signed [cau_pkg::DATA_W-1:0]      in_a_re,
  input  logic signed [cau_pkg::DATA_W-1:0]      in_a_im,
  input  logic signed [cau_pkg::DATA_W-1:0]      in_b_re,
  input  logic signed [cau_pkg::DATA_W-1:0]      in_b_im,
  output logic                                   out_vld,
  output cau_pkg::item_t                         out_item
);
  import cau_pkg::*;

  // Stage 1 registers.
  logic                     s1_vld_r;
  op_t                      s1_op_r;
  logic signed [PROD_W-1:0] p_rr_r, p_ii_r, p_ir_r, p_ri_r, p_s0_r, p_s1_r;
  logic [DATA_W-1:0]        s1_re_r, s1_im_r;
  logic                     s1_sat_r, s1_dz_r;
  logic signed [DATA_W-1:0] s1_ar_r, s1_ai_r, s1_br_r;

  // Stage 2 registers.
  logic                     s2_vld_r;
  op_t                      s2_op_r;
  logic signed [PROD_W:0]   x_re_r, x_im_r;
  logic [PROD_W-1:0]        s2_d_r, s2_m_r;
  logic [DATA_W-1:0]        s2_re_r, s2_im_r;
  logic                     s2_sat_r, s2_dz_r, s2_brneg_r;

  // Stage 3 registers.
  logic                     s3_vld_r;
  item_t                    s3_item_r;

  // Stage 1 logic.
  logic signed [DATA_W:0]   ext_ar, ext_ai, ext_br, ext_bi;
  logic [DATA_W:0]          res_re, res_im;
  logic [DATA_W-1:0]        s1_re_nxt, s1_im_nxt;
  logic                     s1_sat_nxt, s1_dz_nxt;
  logic signed [DATA_W-1:0] sq0, sq1;
  logic signed [PROD_W-1:0] p_rr, p_ii, p_ir, p_ri, p_s0, p_s1;

  assign ext_ar = {in_a_re[DATA_W-1], in_a_re};
  assign ext_ai = {in_a_im[DATA_W-1], in_a_im};
  assign ext_br = {in_b_re[DATA_W-1], in_b_re};
  assign ext_bi = {in_b_im[DATA_W-1], in_b_im};

  // Magnitude commands square the first operand, complex divide the second.
  assign sq0  = (in_op == OP_ABS2 || in_op == OP_ABS) ? in_a_re : in_b_re;
  assign sq1  = (in_op == OP_ABS2 || in_op == OP_ABS) ? in_a_im : in_b_im;
  assign p_rr = in_a_re * in_b_re;
  assign p_ii = in_a_im * in_b_im;
  assign p_ir = in_a_im * in_b_re;
  assign p_ri = in_a_re * in_b_im;
  assign p_s0 = sq0 * sq0;
  assign p_s1 = sq1 * sq1;

  // The add, subtract, conjugate and negate results are finished here; divide by zero is flagged.
  always_comb begin
    res_re     = '0;
    res_im     = '0;
    s1_dz_nxt  = 1'b0;
    case (in_op)
      OP_ADD: begin
        res_re = sat_sum(ext_ar + ext_br);
        res_im = sat_sum(ext_ai + ext_bi);
      end
      OP_SUB: begin
        res_re = sat_sum(ext_ar - ext_br);
        res_im = sat_sum(ext_ai - ext_bi);
      end
      OP_CONJ: begin
        res_re = sat_sum(ext_ar);
        res_im = sat_sum(-ext_ai);
      end
      OP_NEG: begin
        res_re = sat_sum(-ext_ar);
        res_im = sat_sum(-ext_ai);
      end
      OP_CDIV: s1_dz_nxt = (in_b_re == '0) && (in_b_im == '0);
      OP_RDIV: s1_dz_nxt = (in_b_re == '0);
      default: begin
        res_re = '0;
        res_im = '0;
      end
    endcase
    s1_re_nxt  = res_re[DATA_W-1:0];
    s1_im_nxt  = res_im[DATA_W-1:0];
    s1_sat_nxt = res_re[DATA_W] | res_im[DATA_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_op_r  <= in_op;
    p_rr_r   <= p_rr;
    p_ii_r   <= p_ii;
    p_ir_r   <= p_ir;
    p_ri_r   <= p_ri;
    p_s0_r   <= p_s0;
    p_s1_r   <= p_s1;
    s1_re_r  <= s1_re_nxt;
    s1_im_r  <= s1_im_nxt;
    s1_sat_r <= s1_sat_nxt;
    s1_dz_r  <= s1_dz_nxt;
    s1_ar_r  <= in_a_re;
    s1_ai_r  <= in_a_im;
    s1_br_r  <= in_b_re;
  end

  // Stage 2: signed sums of the products, divisor and squared magnitude.
  logic signed [PROD_W:0]   e_rr, e_ii, e_ir, e_ri, e_ar, e_ai;
  logic signed [PROD_W:0]   x_re_nxt, x_im_nxt;
  logic signed [PROD_W-1:0] e_br;
  logic [PROD_W-1:0]        m_nxt, d_nxt;

  assign e_rr  = {p_rr_r[PROD_W-1], p_rr_r};
  assign e_ii  = {p_ii_r[PROD_W-1], p_ii_r};
  assign e_ir  = {p_ir_r[PROD_W-1], p_ir_r};
  assign e_ri  = {p_ri_r[PROD_W-1], p_ri_r};
  assign e_ar  = {{(PROD_W-DATA_W+1){s1_ar_r[DATA_W-1]}}, s1_ar_r};
  assign e_ai  = {{(PROD_W-DATA_W+1){s1_ai_r[DATA_W-1]}}, s1_ai_r};
  assign e_br  = {{(PROD_W-DATA_W){s1_br_r[DATA_W-1]}}, s1_br_r};
  assign m_nxt = $unsigned(p_s0_r) + $unsigned(p_s1_r);

  always_comb begin
    x_re_nxt = e_rr - e_ii;
    x_im_nxt = e_ir + e_ri;
    d_nxt    = m_nxt;
    case (s1_op_r)
      OP_CDIV: begin
        x_re_nxt = e_rr + e_ii;
        x_im_nxt = e_ir - e_ri;
      end
      OP_RDIV: begin
        x_re_nxt = e_ar;
        x_im_nxt = e_ai;
        d_nxt    = s1_br_r[DATA_W-1] ? $unsigned(-e_br) : $unsigned(e_br);
      end
      default: begin
        x_re_nxt = e_rr - e_ii;
        x_im_nxt = e_ir + e_ri;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_op_r    <= s1_op_r;
    x_re_r     <= x_re_nxt;
    x_im_r     <= x_im_nxt;
    s2_d_r     <= d_nxt;
    s2_m_r     <= m_nxt;
    s2_re_r    <= s1_re_r;
    s2_im_r    <= s1_im_r;
    s2_sat_r   <= s1_sat_r;
    s2_dz_r    <= s1_dz_r;
    s2_brneg_r <= s1_br_r[DATA_W-1];
  end

  // Stage 3: sign and magnitude, early overflow check, divider and root setup.
  logic [PROD_W:0]   neg_x_re, neg_x_im;
  logic [PROD_W-1:0] mre, mim;
  logic              rdiv;
  item_t             s3_item_nxt;

  assign neg_x_re = $unsigned(-x_re_r);
  assign neg_x_im = $unsigned(-x_im_r);
  assign mre      = x_re_r[PROD_W] ? neg_x_re[PROD_W-1:0] : x_re_r[PROD_W-1:0];
  assign mim      = x_im_r[PROD_W] ? neg_x_im[PROD_W-1:0] : x_im_r[PROD_W-1:0];
  assign rdiv     = (s2_op_r == OP_RDIV);

  always_comb begin
    s3_item_nxt            = '0;
    s3_item_nxt.op         = s2_op_r;
    s3_item_nxt.simple_re  = s2_re_r;
    s3_item_nxt.simple_im  = s2_im_r;
    s3_item_nxt.simple_sat = s2_sat_r;
    s3_item_nxt.dz         = s2_dz_r;
    s3_item_nxt.neg_re     = x_re_r[PROD_W] ^ (rdiv & s2_brneg_r);
    s3_item_nxt.neg_im     = x_im_r[PROD_W] ^ (rdiv & s2_brneg_r);
    s3_item_nxt.ovf_re     = PRESAT_W'(mre) >= (PRESAT_W'(s2_d_r) << (QBITS - FRAC_BITS));
    s3_item_nxt.ovf_im     = PRESAT_W'(mim) >= (PRESAT_W'(s2_d_r) << (QBITS - FRAC_BITS));
    s3_item_nxt.mag_re     = (s2_op_r == OP_ABS2) ? s2_m_r : mre;
    s3_item_nxt.mag_im     = mim;
    s3_item_nxt.d          = s2_d_r;
    s3_item_nxt.rem_re     = REM_W'({mre, {FRAC_BITS{1'b0}}});
    s3_item_nxt.rem_im     = REM_W'({mim, {FRAC_BITS{1'b0}}});
    s3_item_nxt.q_re       = '0;
    s3_item_nxt.q_im       = '0;
    s3_item_nxt.sq_n       = s2_m_r;
    s3_item_nxt.sq_res     = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_item_r <= s3_item_nxt;
  end

  assign out_vld  = s3_vld_r;
  assign out_item = s3_item_r;

endmodule

[hdl/cau_iter.sv]
// Iteration stages: one restoring divide step for both lanes per register stage,
// plus one square root step while root bits remain. Depends on cau_pkg.
module cau_iter (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  cau_pkg::item_t  in_item,
  output logic            out_vld,
  output cau_pkg::item_t  out_item
);
  import cau_pkg::*;

  logic [ITER_STAGES-1:0] vld_r;
  item_t                  stg_r   [ITER_STAGES];
  item_t                  stg_nxt [ITER_STAGES];
  item_t                  src     [ITER_STAGES];

  assign src[0] = in_item;

  for (genvar k = 0; k < ITER_STAGES; k++) begin : g_stage
    localparam int QIDX = DIV_STEPS - 1 - k;

    if (k > 0) begin : g_link
      assign src[k] = stg_r[k-1];
    end

    // Divide step on both lanes; quotient bit QIDX is decided here.
    logic [REM_W-1:0] dsh;
    item_t            div_out;
    assign dsh = REM_W'(src[k].d) << QIDX;

    always_comb begin
      div_out = src[k];
      if (src[k].rem_re >= dsh) begin
        div_out.rem_re     = src[k].rem_re - dsh;
        div_out.q_re[QIDX] = 1'b1;
      end
      if (src[k].rem_im >= dsh) begin
        div_out.rem_im     = src[k].rem_im - dsh;
        div_out.q_im[QIDX] = 1'b1;
      end
    end

    // Square root step: one result bit per stage while bits remain.
    if (k < SQ_STEPS) begin : g_sqrt
      localparam logic [PROD_W-1:0] SQ_BIT = PROD_W'(1) << (PROD_W - 2 - 2 * k);
      logic [PROD_W-1:0] trial;
      assign trial = src[k].sq_res | SQ_BIT;
      always_comb begin
        stg_nxt[k] = div_out;
        if (src[k].sq_n >= trial) begin
          stg_nxt[k].sq_n   = src[k].sq_n - trial;
          stg_nxt[k].sq_res = (src[k].sq_res >> 1) | SQ_BIT;
        end else begin
          stg_nxt[k].sq_res = src[k].sq_res >> 1;
        end
      end
    end else begin : g_nosqrt
      assign stg_nxt[k] = div_out;
    end

    always_ff @(posedge clk) begin
      stg_r[k] <= stg_nxt[k];
    end
  end

  // Valid bits travel alongside the stage registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[ITER_STAGES-2:0], in_vld};
    end
  end

  assign out_vld  = vld_r[ITER_STAGES-1];
  assign out_item = stg_r[ITER_STAGES-1];

endmodule

[hdl/cau_back.sv]
// Back end: final rounding of quotients, products and roots, then saturation and
// status. Two register stages; depends on cau_pkg.
module cau_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  cau_pkg::item_t              in_item,
  output logic                        out_vld,
  output logic [cau_pkg::DATA_W-1:0]  out_re,
  output logic [cau_pkg::DATA_W-1:0]  out_im,
  output cau_pkg::status_t            out_status
);
  import cau_pkg::*;

  localparam logic [MAG_W-1:0] HALF = MAG_W'(1) << (FRAC_BITS - 1);

  logic              f1_vld_r;
  op_t               f1_op_r;
  logic [DATA_W-1:0] f1_re_r, f1_im_r;
  logic              f1_sat_r, f1_dz_r, f1_neg_re_r, f1_neg_im_r;
  logic [MAG_W-1:0]  f1_mr_r, f1_mi_r;

  logic              out_vld_r;
  logic [DATA_W-1:0] out_re_r, out_im_r;
  status_t           out_status_r;

  // Rounding: half up on products, remainder test on quotients, root fix-up.
  logic             rb_re, rb_im;
  logic [MAG_W-1:0] mr_nxt, mi_nxt;

  assign rb_re = {in_item.rem_re[PROD_W-1:0], 1'b0} >= {1'b0, in_item.d};
  assign rb_im = {in_item.rem_im[PROD_W-1:0], 1'b0} >= {1'b0, in_item.d};

  always_comb begin
    mr_nxt = '0;
    mi_nxt = '0;
    case (in_item.op)
      OP_MUL: begin
        mr_nxt = (MAG_W'(in_item.mag_re) + HALF) >> FRAC_BITS;
        mi_nxt = (MAG_W'(in_item.mag_im) + HALF) >> FRAC_BITS;
      end
      OP_ABS2: mr_nxt = (MAG_W'(in_item.mag_re) + HALF) >> FRAC_BITS;
      OP_CDIV, OP_RDIV: begin
        mr_nxt = in_item.ovf_re ? {MAG_W{1'b1}} : MAG_W'(in_item.q_re) + MAG_W'(rb_re);
        mi_nxt = in_item.ovf_im ? {MAG_W{1'b1}} : MAG_W'(in_item.q_im) + MAG_W'(rb_im);
      end
      OP_ABS: begin
        mr_nxt = MAG_W'(in_item.sq_res) + MAG_W'(in_item.sq_n > in_item.sq_res);
      end
      default: begin
        mr_nxt = '0;
        mi_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
    end else begin
      f1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    f1_op_r     <= in_item.op;
    f1_re_r     <= in_item.simple_re;
    f1_im_r     <= in_item.simple_im;
    f1_sat_r    <= in_item.simple_sat;
    f1_dz_r     <= in_item.dz;
    f1_neg_re_r <= in_item.neg_re;
    f1_neg_im_r <= in_item.neg_im;
    f1_mr_r     <= mr_nxt;
    f1_mi_r     <= mi_nxt;
  end

  // Saturation, result selection and status.
  logic [DATA_W:0]   pk_re, pk_im, pk_abs;
  logic [DATA_W-1:0] re_nxt, im_nxt;
  logic              sat_nxt, dz_nxt;
  status_t           status_nxt;

  assign pk_re  = pack_mag(f1_neg_re_r, f1_mr_r);
  assign pk_im  = pack_mag(f1_neg_im_r, f1_mi_r);
  assign pk_abs = pack_mag(1'b0, f1_mr_r);

  always_comb begin
    re_nxt  = '0;
    im_nxt  = '0;
    sat_nxt = 1'b0;
    dz_nxt  = 1'b0;
    case (f1_op_r)
      OP_ADD, OP_SUB, OP_CONJ, OP_NEG: begin
        re_nxt  = f1_re_r;
        im_nxt  = f1_im_r;
        sat_nxt = f1_sat_r;
      end
      OP_MUL: begin
        re_nxt  = pk_re[DATA_W-1:0];
        im_nxt  = pk_im[DATA_W-1:0];
        sat_nxt = pk_re[DATA_W] | pk_im[DATA_W];
      end
      OP_CDIV, OP_RDIV: begin
        dz_nxt = f1_dz_r;
        if (!f1_dz_r) begin
          re_nxt  = pk_re[DATA_W-1:0];
          im_nxt  = pk_im[DATA_W-1:0];
          sat_nxt = pk_re[DATA_W] | pk_im[DATA_W];
        end
      end
      OP_ABS2, OP_ABS: begin
        re_nxt  = pk_abs[DATA_W-1:0];
        sat_nxt = pk_abs[DATA_W];
      end
      default: begin
        re_nxt = '0;
        im_nxt = '0;
      end
    endcase
    if (dz_nxt) begin
      status_nxt = ST_DIV0;
    end else if (sat_nxt) begin
      status_nxt = ST_SAT;
    end else begin
      status_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_re_r     <= re_nxt;
    out_im_r     <= im_nxt;
    out_status_r <= status_nxt;
  end

  assign out_vld    = out_vld_r;
  assign out_re     = out_re_r;
  assign out_im     = out_im_r;
  assign out_status = out_status_r;

endmodule
